// ===== hdl/trajectory_limit_checker_core_macros.svh =====
// Assertion macros for the trajectory limit checker.
`ifndef TRAJECTORY_LIMIT_CHECKER_CORE_MACROS_SVH
`define TRAJECTORY_LIMIT_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Implication or plain property, checked on every rising edge out of reset
`define TLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen
`define TLC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TLC_ASSERT(lbl, prop, msg)
`define TLC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/tlc_pkg.sv =====
// Shared types, constants and microcode table of the trajectory limit checker.
package tlc_pkg;

  // Field widths
  localparam int unsigned AccelW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned ReasonW = 3;

  // Shared multiplier operand and product widths
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Lateral limit is scaled by 2^22 to line up with speed^2 * curvature
  localparam int unsigned LatShift = 22;
  localparam int unsigned LatW     = 48;

  localparam logic [1:0] MinPoints = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_LON_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LON_MAX = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LAT_LIM = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_JERK_MIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_JERK_MAX = 3'd4;

  // Register reset values
  localparam logic [CfgW-1:0] RST_LON_MIN  = 16'hFC00;
  localparam logic [CfgW-1:0] RST_LON_MAX  = 16'h0400;
  localparam logic [CfgW-1:0] RST_LAT_LIM  = 16'h0400;
  localparam logic [CfgW-1:0] RST_JERK_MIN = 16'hFC00;
  localparam logic [CfgW-1:0] RST_JERK_MAX = 16'h0400;

  // Failure reasons
  localparam logic [ReasonW-1:0] REASON_NONE  = 3'd0;
  localparam logic [ReasonW-1:0] REASON_ACCEL = 3'd1;
  localparam logic [ReasonW-1:0] REASON_LAT   = 3'd2;
  localparam logic [ReasonW-1:0] REASON_TIME  = 3'd3;
  localparam logic [ReasonW-1:0] REASON_JERK  = 3'd4;
  localparam logic [ReasonW-1:0] REASON_FEW   = 3'd5;

  typedef struct packed {
    logic signed [15:0] accel;
    logic [15:0]        speed;
    logic signed [15:0] curvature;
    logic [31:0]        time_ms;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic         still_valid;
    logic [2:0]   fail_reason;
    logic         verdict_final;
  } out_item_t;

  // Microprogram steps
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_SQ,
    STEP_LAT,
    STEP_JMIN,
    STEP_JMAX,
    STEP_FIN
  } step_e;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_LAT,
    MUL_JMIN,
    MUL_JMAX
  } mul_sel_e;

  // One control word
  typedef struct packed {
    step_e    step;      // current step, for the datapath
    mul_sel_e mul_sel;
    logic     mul_en;
    logic     cmp_lat;   // register lateral compare
    logic     cmp_jmin;  // register lower jerk compare
    logic     wait_in;   // hold here until an input transfer
    logic     wait_out;  // hold here until the output slot is free, then finish
    logic     skip_jerk; // jump to jmp when no jerk check is due
    step_e    nxt;
    step_e    jmp;
  } ctrl_t;

  // Conditions seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic no_jerk;
  } seq_cond_t;

  // Microcode ROM
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '{step: s, mul_sel: MUL_SQ, mul_en: 1'b0, cmp_lat: 1'b0, cmp_jmin: 1'b0,
          wait_in: 1'b0, wait_out: 1'b0, skip_jerk: 1'b0, nxt: STEP_IDLE,
          jmp: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.nxt     = STEP_SQ;
      end
      STEP_SQ: begin
        w.mul_sel = MUL_SQ;
        w.mul_en  = 1'b1;
        w.nxt     = STEP_LAT;
      end
      STEP_LAT: begin
        w.mul_sel = MUL_LAT;
        w.mul_en  = 1'b1;
        w.nxt     = STEP_JMIN;
      end
      STEP_JMIN: begin
        w.mul_sel   = MUL_JMIN;
        w.mul_en    = 1'b1;
        w.cmp_lat   = 1'b1;
        w.skip_jerk = 1'b1;
        w.nxt       = STEP_JMAX;
        w.jmp       = STEP_FIN;
      end
      STEP_JMAX: begin
        w.mul_sel  = MUL_JMAX;
        w.mul_en   = 1'b1;
        w.cmp_jmin = 1'b1;
        w.nxt      = STEP_FIN;
      end
      STEP_FIN: begin
        w.wait_out = 1'b1;
        w.nxt      = STEP_IDLE;
      end
      default: begin
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/tlc_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
module tlc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlc_pkg::seq_cond_t cond_i,
  output tlc_pkg::ctrl_t     ctrl_o
);
  import tlc_pkg::*;

  step_e step_q, step_d;
  ctrl_t word;

  // Step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Fetch and next step
  always_comb begin
    word   = ucode(step_q);
    step_d = word.nxt;
    if (word.wait_in && !cond_i.in_valid) begin
      step_d = step_q;
    end else if (word.wait_out && !cond_i.out_free) begin
      step_d = step_q;
    end else if (word.skip_jerk && cond_i.no_jerk) begin
      step_d = word.jmp;
    end
  end

  assign ctrl_o = word;

endmodule

// ===== hdl/trajectory_limit_checker_core.sv =====
// Top level of the trajectory limit checker: registers, datapath and output slot.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i         | point in
//  out     | out_valid_o, out_ready_i, out_data_o      | verdict out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data | register write
//
// A point's result is loaded in the finishing step, after the square, lateral, lower jerk and
// upper jerk steps (upper jerk skipped when no jerk check is due: first point, time not
// increasing), and the next point can be taken in the cycle after that. The steps are set by one
// shared 33x18 multiplier that forms speed^2, the lateral product and both jerk bound products.
// Reset clears the limits to their defaults and the trajectory state to zero.
// The finishing step holds while the output register is full and not taken.
`include "trajectory_limit_checker_core_macros.svh"

module trajectory_limit_checker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tlc_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tlc_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tlc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tlc_pkg::CfgW-1:0]       cfg_data_i
);
  import tlc_pkg::*;

  // Limit registers
  logic signed [CfgW-1:0] lon_min_q, lon_max_q, jerk_min_q, jerk_max_q;
  logic [CfgW-1:0]        lat_lim_q;

  // Trajectory state
  logic signed [AccelW-1:0] prev_accel_q, prev_accel_d;
  logic [TimeW-1:0]         prev_time_q, prev_time_d;
  logic [1:0]               points_seen_q, points_seen_d;
  logic                     failed_q, failed_d;
  logic [ReasonW-1:0]       first_reason_q, first_reason_d;

  // Working registers
  in_item_t                 pt_q;
  logic signed [MulPW-1:0]  mul_q;
  logic                     lat_fail_q, jmin_fail_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  ctrl_t      ctrl;
  seq_cond_t  cond;
  logic       in_xfer, out_free, fin;

  logic signed [MulAW-1:0]  op_a;
  logic signed [MulBW-1:0]  op_b;
  logic signed [MulPW-1:0]  product;
  logic [16:0]              kmag;
  logic [TimeW-1:0]         dt;
  logic signed [16:0]       da;
  logic signed [26:0]       da_ext, da1000;
  logic signed [MulPW-1:0]  da1000_w;
  logic [LatW-1:0]          lat_lim_w;
  logic                     few, accel_fail, time_up, need_jerk, jmax_fail, jerk_fail;
  logic [ReasonW-1:0]       reason;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ctrl.wait_in;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fin         = ctrl.wait_out && out_free;

  // Sequencer
  assign cond = '{in_valid: in_valid_i, out_free: out_free, no_jerk: !need_jerk};

  tlc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  // Limit register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_min_q  <= RST_LON_MIN;
      lon_max_q  <= RST_LON_MAX;
      lat_lim_q  <= RST_LAT_LIM;
      jerk_min_q <= RST_JERK_MIN;
      jerk_max_q <= RST_JERK_MAX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LON_MIN:  lon_min_q  <= cfg_data_i;
        REG_LON_MAX:  lon_max_q  <= cfg_data_i;
        REG_LAT_LIM:  lat_lim_q  <= cfg_data_i;
        REG_JERK_MIN: jerk_min_q <= cfg_data_i;
        REG_JERK_MAX: jerk_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Derived operands
  assign kmag = pt_q.curvature[15] ? (17'd0 - {1'b1, pt_q.curvature})
                                   : {1'b0, pt_q.curvature};
  assign dt   = pt_q.time_ms - prev_time_q;
  assign da   = {pt_q.accel[15], pt_q.accel} - {prev_accel_q[15], prev_accel_q};
  // da * 1000 as 1024 - 16 - 8
  assign da_ext   = {{10{da[16]}}, da};
  assign da1000   = (da_ext <<< 10) - (da_ext <<< 4) - (da_ext <<< 3);
  assign da1000_w = {{(MulPW-27){da1000[26]}}, da1000};
  assign lat_lim_w = {{(LatW-CfgW-LatShift){1'b0}}, lat_lim_q, {LatShift{1'b0}}};

  // Shared multiplier operand selection
  always_comb begin
    case (ctrl.mul_sel)
      MUL_SQ: begin
        op_a = {17'd0, pt_q.speed};
        op_b = {2'b00, pt_q.speed};
      end
      MUL_LAT: begin
        op_a = {1'b0, mul_q[31:0]};
        op_b = {1'b0, kmag};
      end
      MUL_JMIN: begin
        op_a = {1'b0, dt};
        op_b = {{2{jerk_min_q[15]}}, jerk_min_q};
      end
      MUL_JMAX: begin
        op_a = {1'b0, dt};
        op_b = {{2{jerk_max_q[15]}}, jerk_max_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign product = op_a * op_b;

  // Point capture, product register and compare flags
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pt_q <= in_data_i;
    end
    if (ctrl.mul_en) begin
      mul_q <= product;
    end
    if (ctrl.cmp_lat) begin
      lat_fail_q <= mul_q[LatW-1:0] > lat_lim_w;
    end
    if (ctrl.cmp_jmin) begin
      jmin_fail_q <= da1000_w < mul_q;
    end
  end

  // Verdict of the finishing step
  always_comb begin
    few        = pt_q.last_point && (points_seen_q == 2'd0);
    accel_fail = (pt_q.accel < lon_min_q) || (pt_q.accel > lon_max_q);
    time_up    = pt_q.time_ms > prev_time_q;
    need_jerk  = (points_seen_q != 2'd0) && time_up;
    jmax_fail  = da1000_w > mul_q;
    jerk_fail  = need_jerk && (jmin_fail_q || jmax_fail);

    if (few) begin
      reason = REASON_FEW;
    end else if (accel_fail) begin
      reason = REASON_ACCEL;
    end else if (lat_fail_q) begin
      reason = REASON_LAT;
    end else if ((points_seen_q != 2'd0) && !time_up) begin
      reason = REASON_TIME;
    end else if (jerk_fail) begin
      reason = REASON_JERK;
    end else begin
      reason = REASON_NONE;
    end

    failed_d       = failed_q;
    first_reason_d = first_reason_q;
    if (!failed_q && (reason != REASON_NONE)) begin
      failed_d       = 1'b1;
      first_reason_d = reason;
    end

    prev_accel_d  = pt_q.accel;
    prev_time_d   = pt_q.time_ms;
    points_seen_d = (points_seen_q < MinPoints) ? points_seen_q + 2'd1 : points_seen_q;
  end

  // Trajectory state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_accel_q   <= '0;
      prev_time_q    <= '0;
      points_seen_q  <= '0;
      failed_q       <= 1'b0;
      first_reason_q <= REASON_NONE;
    end else if (fin) begin
      if (pt_q.last_point) begin
        prev_accel_q   <= '0;
        prev_time_q    <= '0;
        points_seen_q  <= '0;
        failed_q       <= 1'b0;
        first_reason_q <= REASON_NONE;
      end else begin
        prev_accel_q   <= prev_accel_d;
        prev_time_q    <= prev_time_d;
        points_seen_q  <= points_seen_d;
        failed_q       <= failed_d;
        first_reason_q <= first_reason_d;
      end
    end
  end

  // Output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_q <= '{still_valid: !failed_d, fail_reason: first_reason_d,
                 verdict_final: pt_q.last_point};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `TLC_ASSERT(a_busy_after_xfer, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while busy")
  `TLC_ASSERT(a_valid_no_reason, out_valid_o && out_data_o.still_valid |-> out_data_o.fail_reason == REASON_NONE, "reason without failure")
  `TLC_ASSERT_NEVER(a_points_sat, points_seen_q == 2'd3, "point count past saturation")

endmodule

// ===== test/tb_trajectory_limit_checker_core.sv =====
// Self-checking testbench for trajectory_limit_checker_core with its own limit-check predictor.
module tb_trajectory_limit_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tlc_pkg::*;

  localparam int    HalfPeriod = 10;
  localparam int    ResetCycles = 7;
  localparam int    LongHold = 300;
  localparam int    DrainCycles = 12;
  localparam longint MsPerS = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  trajectory_limit_checker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #HalfPeriod;
    clk_i = 1'b0;
    #HalfPeriod;
  end

  // Predictor copy of the limit registers
  logic [CfgW-1:0] lim_lon_min  = RST_LON_MIN;
  logic [CfgW-1:0] lim_lon_max  = RST_LON_MAX;
  logic [CfgW-1:0] lim_lat      = RST_LAT_LIM;
  logic [CfgW-1:0] lim_jerk_min = RST_JERK_MIN;
  logic [CfgW-1:0] lim_jerk_max = RST_JERK_MAX;

  // Predictor copy of the per-trajectory state
  logic [AccelW-1:0]  trj_prev_accel = '0;
  logic [TimeW-1:0]   trj_prev_time = '0;
  logic [1:0]         trj_points = '0;
  logic               trj_failed = 1'b0;
  logic [ReasonW-1:0] trj_reason = REASON_NONE;

  in_item_t  point_q[$];    // points waiting to be offered
  out_item_t verdict_q[$];  // verdicts owed by the block, oldest first

  int  mismatch_cnt = 0;
  bit  calm = 1'b0;         // no idling on either side
  int  hold_reqs = 0;       // long receiver hold-offs asked for

  // Keep only the first failure of a trajectory
  function automatic void latch_fail(input logic [ReasonW-1:0] why);
    if (!trj_failed) begin
      trj_failed = 1'b1;
      trj_reason = why;
    end
  endfunction

  // Check one point against the limits and advance the trajectory state
  function automatic out_item_t judge_point(input in_item_t p);
    longint    acc, kmag, lat, lim, dt, dacc;
    out_item_t r;
    acc  = $signed(p.accel);
    kmag = $signed(p.curvature);
    if (kmag < 0) kmag = -kmag;
    lat  = longint'(p.speed) * longint'(p.speed) * kmag;
    lim  = longint'(lim_lat) << LatShift;

    if (p.last_point && (trj_points + 2'd1) < MinPoints) begin
      latch_fail(REASON_FEW);
    end else if (!trj_failed) begin
      if (acc < $signed(lim_lon_min) || acc > $signed(lim_lon_max)) begin
        latch_fail(REASON_ACCEL);
      end else if (lat > lim) begin
        latch_fail(REASON_LAT);
      end else if (trj_points != 2'd0) begin
        if (p.time_ms <= trj_prev_time) begin
          latch_fail(REASON_TIME);
        end else begin
          dt   = longint'(p.time_ms - trj_prev_time);
          dacc = (acc - longint'($signed(trj_prev_accel))) * MsPerS;
          if (dacc < longint'($signed(lim_jerk_min)) * dt ||
              dacc > longint'($signed(lim_jerk_max)) * dt) begin
            latch_fail(REASON_JERK);
          end
        end
      end
    end

    trj_prev_accel = p.accel;
    trj_prev_time  = p.time_ms;
    if (trj_points < MinPoints) trj_points = trj_points + 2'd1;

    r.still_valid   = !trj_failed;
    r.fail_reason   = trj_reason;
    r.verdict_final = p.last_point;

    // closing point clears the trajectory
    if (p.last_point) begin
      trj_prev_accel = '0;
      trj_prev_time  = '0;
      trj_points     = '0;
      trj_failed     = 1'b0;
      trj_reason     = REASON_NONE;
    end
    return r;
  endfunction

  // Point driver: offers queued points, with random gaps between them unless calm is set
  always @(posedge clk_i or negedge rst_ni) begin
    int gap_left;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) verdict_q.push_back(judge_point(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (point_q.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 15);
            in_valid_i <= 1'b0;
          end else begin
            in_data_i  <= point_q.pop_front();
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor: checks each transfer, and paces out_ready_i
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int        hold_done;
    int        hold_left;
    int        burst_left;
    bit        burst_rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_done  = 0;
      hold_left  = 0;
      burst_left = 0;
      burst_rdy  = 1'b1;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict %p", $time, out_data_o);
          mismatch_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.still_valid !== want.still_valid) begin
            $display("%0t: still_valid expected %0b actual %0b", $time,
                     want.still_valid, out_data_o.still_valid);
            mismatch_cnt++;
          end
          if (out_data_o.fail_reason !== want.fail_reason) begin
            $display("%0t: fail_reason expected %0d actual %0d", $time,
                     want.fail_reason, out_data_o.fail_reason);
            mismatch_cnt++;
          end
          if (out_data_o.verdict_final !== want.verdict_final) begin
            $display("%0t: verdict_final expected %0b actual %0b", $time,
                     want.verdict_final, out_data_o.verdict_final);
            mismatch_cnt++;
          end
        end
      end

      // long hold-off so the block backs up into its input
      if (hold_reqs != hold_done) begin
        hold_done++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          burst_rdy  = ($urandom_range(0, 2) != 0);
        end
        burst_left--;
        out_ready_i <= burst_rdy;
      end
    end
  end

  // One register write, mirrored into the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LON_MIN:  lim_lon_min  = val;
      REG_LON_MAX:  lim_lon_max  = val;
      REG_LAT_LIM:  lim_lat      = val;
      REG_JERK_MIN: lim_jerk_min = val;
      REG_JERK_MAX: lim_jerk_max = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [CfgW-1:0] lon_lo, input logic [CfgW-1:0] lon_hi,
                            input logic [CfgW-1:0] lat, input logic [CfgW-1:0] jrk_lo,
                            input logic [CfgW-1:0] jrk_hi);
    write_reg(REG_LON_MIN, lon_lo);
    write_reg(REG_LON_MAX, lon_hi);
    write_reg(REG_LAT_LIM, lat);
    write_reg(REG_JERK_MIN, jrk_lo);
    write_reg(REG_JERK_MAX, jrk_hi);
  endtask

  // Wait until every point is in and every verdict is out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (point_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
  endtask

  function automatic in_item_t mk_point(input int a, input int s, input int k,
                                        input logic [31:0] t, input logic last);
    in_item_t p;
    p.accel      = 16'(a);
    p.speed      = 16'(s);
    p.curvature  = 16'(k);
    p.time_ms    = t;
    p.last_point = last;
    return p;
  endfunction

  // Random trajectories: mostly well formed, some noise and broken sequences
  task automatic queue_random(input int n_points);
    int          left, len, kind, acc, lo, hi;
    logic [31:0] t;
    in_item_t    p;
    left = n_points;
    lo = $signed(lim_lon_min);
    hi = $signed(lim_lon_max);
    if (lo > hi) begin
      lo = -32768;
      hi = 32767;
    end
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      len  = (kind == 0) ? 1 : $urandom_range(2, 7);
      if (len > left) len = left;
      acc = lo + int'($urandom_range(0, hi - lo));
      t   = $urandom;
      for (int j = 0; j < len; j++) begin
        if (kind == 1) begin
          p.accel      = 16'($urandom);
          p.speed      = 16'($urandom);
          p.curvature  = 16'($urandom);
          p.time_ms    = $urandom;
          p.last_point = (j == len - 1) || ($urandom_range(0, 7) == 0);
        end else begin
          if (j > 0) begin
            case ($urandom_range(0, 19))
              0: t = t - $urandom_range(0, 3);        // stalled or backwards clock
              1: begin                                 // acceleration jump
                t   = t + $urandom_range(1, 200);
                acc = lo + int'($urandom_range(0, hi - lo));
              end
              default: begin
                t   = t + $urandom_range(10, 200);
                acc = acc + int'($urandom_range(0, 16)) - 8;
                if (acc < lo) acc = lo;
                if (acc > hi) acc = hi;
              end
            endcase
          end
          p.accel = acc[15:0];
          p.speed = 16'($urandom_range(0, 6000));
          if ($urandom_range(0, 19) == 0) p.curvature = 16'($urandom);
          else p.curvature = 16'(int'($urandom_range(0, 80)) - 40);
          p.time_ms    = t;
          p.last_point = (j == len - 1);
        end
        point_q.push_back(p);
        left--;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed points under the reset limits
    // lone point: too few points
    point_q.push_back(mk_point(0, 0, 0, 5, 1'b1));
    // lower accel bound exactly, time starting at zero
    point_q.push_back(mk_point(-1024, 0, 0, 0, 1'b0));
    point_q.push_back(mk_point(-1024, 0, 0, 1000, 1'b1));
    // accel and lateral both out: accel wins and is held to the close
    point_q.push_back(mk_point(-1025, 16'hFFFF, -32768, 10, 1'b0));
    point_q.push_back(mk_point(0, 0, 0, 20, 1'b1));
    // accel at top of field on second point
    point_q.push_back(mk_point(1024, 0, 0, 0, 1'b0));
    point_q.push_back(mk_point(32767, 0, 0, 50, 1'b1));
    // lateral exactly at limit passes, one step further fails
    point_q.push_back(mk_point(0, 4096, 256, 0, 1'b0));
    point_q.push_back(mk_point(0, 4096, -257, 100, 1'b1));
    // repeated timestamp
    point_q.push_back(mk_point(0, 0, 0, 100, 1'b0));
    point_q.push_back(mk_point(512, 0, 0, 100, 1'b0));
    point_q.push_back(mk_point(0, 0, 0, 200, 1'b1));
    // time wrapping back to zero is not an increase
    point_q.push_back(mk_point(0, 0, 0, 32'hFFFF_FFFF, 1'b0));
    point_q.push_back(mk_point(0, 0, 0, 0, 1'b1));
    // jerk exactly at upper bound, then just past the lower bound
    point_q.push_back(mk_point(0, 0, 0, 1000, 1'b0));
    point_q.push_back(mk_point(1024, 0, 0, 2000, 1'b0));
    point_q.push_back(mk_point(0, 0, 0, 2999, 1'b1));
    // lone point with every field at an extreme: only the point count counts
    point_q.push_back(mk_point(-32768, 16'hFFFF, -32768, 32'hFFFF_FFFF, 1'b1));
    // clean trajectory after the others closed
    point_q.push_back(mk_point(0, 0, 32767, 1, 1'b0));
    point_q.push_back(mk_point(0, 0, 0, 2, 1'b1));
    queue_random(50);
    wait_drained();

    // Widest limits, plus writes to unused indexes
    set_limits(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    for (int k = int'(REG_JERK_MAX) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), 16'($urandom));
    end
    queue_random(80);
    wait_drained();

    // Tightest limits
    set_limits('0, '0, '0, '0, '0);
    queue_random(40);
    wait_drained();

    // Moderate random limits, with a long hold-off on the verdict side
    set_limits(16'(-int'($urandom_range(128, 2048))), 16'($urandom_range(128, 2048)),
               16'($urandom_range(256, 4096)), 16'(-int'($urandom_range(256, 8192))),
               16'($urandom_range(256, 8192)));
    hold_reqs++;
    queue_random(100);
    wait_drained();

    // Crossed bounds
    set_limits(16'h7FFF, 16'h8000, 16'($urandom), 16'h7FFF, 16'h8000);
    queue_random(30);
    wait_drained();

    // Back to reset limits, running flat out
    calm = 1'b1;
    set_limits(RST_LON_MIN, RST_LON_MAX, RST_LAT_LIM, RST_JERK_MIN, RST_JERK_MAX);
    queue_random(100);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
